// ===== rtl/chi_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// chi_pkg
// Shared sizes, codes, types and helpers of the chained hash table
// (division hash, fixed-depth buckets, insert and delete).
// ---------------------------------------------------------------------------
package chi_pkg;

	// table geometry
	localparam int MAX_BUCKETS  = 16;
	localparam int BUCKET_DEPTH = 8;
	localparam int KEY_BITS     = 31;

	// configuration register width (fixed by the register map)
	localparam int CFG_W = 5;

	// derived widths
	localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
	localparam int REM_W  = BKT_W + 1;
	localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
	localparam int IDX_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int ROW_W  = BUCKET_DEPTH * KEY_BITS;
	localparam int CMP_W  = CFG_W + CNT_W;

	// remainder unit: dividend bits retired per cycle and steps per key
	localparam int STEP_BITS = 4;
	localparam int DIV_STEPS = (KEY_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int DIV_W     = DIV_STEPS * STEP_BITS;
	localparam int STEP_CW   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// request codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// result codes
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_DELETED  = 2'd1;
	localparam logic [1:0] ST_NO_MATCH = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [BUCKET_DEPTH-1:0][KEY_BITS-1:0] row_t;

	// one classified request on its way from front to back
	typedef struct packed {
		logic             op;
		key_t             key;
		logic [BKT_W-1:0] bucket;
	} task_t;

	// bucket count in use: zero acts as one, large values saturate
	function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] cfg);
		logic [CMP_W-1:0] wide;
		wide = CMP_W'(cfg);
		if (wide == '0)
			return CNT_W'(1);
		else if (wide > CMP_W'(MAX_BUCKETS))
			return CNT_W'(MAX_BUCKETS);
		else
			return wide[CNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/chi_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// chi_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module chi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port, holds while idle
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/chi_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// chi_front
// Accepts requests and works out the bucket (key modulo bucket count) with
// a restoring remainder unit, a few dividend bits per cycle.
// ---------------------------------------------------------------------------
module chi_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       req_type,
	input  wire logic [chi_pkg::KEY_BITS-1:0] key,
	input  wire logic [chi_pkg::CNT_W-1:0]  n,
	output logic                            push,
	output chi_pkg::task_t                  push_task,
	input  wire logic                       fifo_full
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]                      state_q;
	logic [chi_pkg::STEP_CW-1:0]     step_q;
	logic [chi_pkg::DIV_W-1:0]       dvd_q;
	logic [chi_pkg::BKT_W-1:0]       rem_q;
	logic [chi_pkg::CNT_W-1:0]       n_q;
	logic                            op_q;
	logic [chi_pkg::KEY_BITS-1:0]    key_q;
	logic [chi_pkg::BKT_W-1:0]       rem_nxt;
	logic                            accept;

	// handshake
	assign in_ready = (state_q == F_IDLE) || ((state_q == F_PUSH) && !fifo_full);
	assign accept   = in_valid && in_ready;
	assign push     = (state_q == F_PUSH) && !fifo_full;

	// classified request: op, key, bucket
	assign push_task = {op_q, key_q, rem_q};

	// restoring remainder steps for this cycle's dividend bits
	always_comb begin
		logic [chi_pkg::BKT_W-1:0] r;
		logic [chi_pkg::REM_W-1:0] t;
		r = rem_q;
		t = '0;
		for (int j = 0; j < chi_pkg::STEP_BITS; j++) begin
			t = {r, dvd_q[chi_pkg::DIV_W-1-j]};
			if (t >= chi_pkg::REM_W'(n_q))
				t = t - chi_pkg::REM_W'(n_q);
			r = t[chi_pkg::BKT_W-1:0];
		end
		rem_nxt = r;
	end

	// request payload and remainder datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req_type;
			key_q <= key;
			dvd_q <= chi_pkg::DIV_W'(key);
			rem_q <= '0;
			n_q   <= n;
		end else if (state_q == F_DIV) begin
			dvd_q <= dvd_q << chi_pkg::STEP_BITS;
			rem_q <= rem_nxt;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_DIV;
						step_q  <= '0;
					end
				end
				F_DIV: begin
					if (step_q == chi_pkg::STEP_CW'(chi_pkg::DIV_STEPS - 1))
						state_q <= F_PUSH;
					else
						step_q <= step_q + chi_pkg::STEP_CW'(1);
				end
				F_PUSH: begin
					if (accept) begin
						state_q <= F_DIV;
						step_q  <= '0;
					end else if (push) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/chi_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// chi_fifo
// Short queue of classified requests between front and back.
// ---------------------------------------------------------------------------
module chi_fifo (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  chi_pkg::task_t push_task,
	output logic           full,
	input  wire logic      pop,
	output chi_pkg::task_t pop_task,
	output logic           empty
);

	chi_pkg::task_t                slot_q [chi_pkg::FIFO_DEPTH];
	logic [chi_pkg::FPTR_W-1:0]    wptr_q;
	logic [chi_pkg::FPTR_W-1:0]    rptr_q;
	logic [chi_pkg::FCNT_W-1:0]    count_q;

	assign full     = (count_q == chi_pkg::FCNT_W'(chi_pkg::FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_task = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_task;
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				if (wptr_q == chi_pkg::FPTR_W'(chi_pkg::FIFO_DEPTH - 1))
					wptr_q <= '0;
				else
					wptr_q <= wptr_q + chi_pkg::FPTR_W'(1);
			end
			if (pop) begin
				if (rptr_q == chi_pkg::FPTR_W'(chi_pkg::FIFO_DEPTH - 1))
					rptr_q <= '0;
				else
					rptr_q <= rptr_q + chi_pkg::FPTR_W'(1);
			end
			if (push && !pop)
				count_q <= count_q + chi_pkg::FCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - chi_pkg::FCNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/chi_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// chi_back
// Runs inserts and deletes on a bucket row: reads it, on a delete compares
// every entry at once, rewrites a changed row and fill count, gives the result.
// ---------------------------------------------------------------------------
module chi_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        fifo_empty,
	input  chi_pkg::task_t                   head_task,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic [chi_pkg::BKT_W-1:0]        bucket
);

	localparam logic B_IDLE = 1'b0;
	localparam logic B_EXEC = 1'b1;

	logic                           state_q;
	chi_pkg::task_t                 cur_q;
	logic [chi_pkg::FILL_W-1:0]     fill_q [chi_pkg::MAX_BUCKETS];
	logic                           out_valid_q;
	logic [1:0]                     status_q;
	logic [chi_pkg::BKT_W-1:0]      bucket_q;

	logic [chi_pkg::ROW_W-1:0]      rd_data;
	chi_pkg::row_t                  rd_row;
	chi_pkg::row_t                  new_row;
	logic [chi_pkg::FILL_W-1:0]     fill;
	logic [chi_pkg::FILL_W-1:0]     new_fill;
	logic [1:0]                     new_status;
	logic                           row_we;
	logic                           out_free;
	logic                           exec;

	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == B_IDLE) && !fifo_empty;
	assign exec     = (state_q == B_EXEC) && out_free;
	assign rd_row   = chi_pkg::row_t'(rd_data);
	assign fill     = fill_q[cur_q.bucket];

	// bucket rows, one row per bucket
	chi_ram #(
		.WIDTH (chi_pkg::ROW_W),
		.DEPTH (chi_pkg::MAX_BUCKETS)
	) u_rows (
		.clk   (clk),
		.we    (row_we),
		.waddr (cur_q.bucket),
		.wdata (chi_pkg::ROW_W'(new_row)),
		.re    (pop),
		.raddr (head_task.bucket),
		.rdata (rd_data)
	);

	// row update: append on insert, remove first match and close the gap on delete
	always_comb begin
		logic [chi_pkg::BUCKET_DEPTH-1:0] hit;
		logic [chi_pkg::IDX_W-1:0]        idx;
		logic                             found;
		new_row    = rd_row;
		new_fill   = fill;
		new_status = chi_pkg::ST_INSERTED;
		row_we     = 1'b0;
		hit        = '0;
		idx        = '0;
		found      = 1'b0;
		if (cur_q.op == chi_pkg::OP_INSERT) begin
			if (fill == chi_pkg::FILL_W'(chi_pkg::BUCKET_DEPTH)) begin
				new_status = chi_pkg::ST_FULL;
			end else begin
				new_row[fill[chi_pkg::IDX_W-1:0]] = cur_q.key;
				new_fill   = fill + chi_pkg::FILL_W'(1);
				new_status = chi_pkg::ST_INSERTED;
				row_we     = exec;
			end
		end else begin
			for (int i = 0; i < chi_pkg::BUCKET_DEPTH; i++)
				hit[i] = (chi_pkg::FILL_W'(i) < fill) && (rd_row[i] == cur_q.key);
			// first match wins
			for (int i = chi_pkg::BUCKET_DEPTH - 1; i >= 0; i--) begin
				if (hit[i]) begin
					idx   = chi_pkg::IDX_W'(i);
					found = 1'b1;
				end
			end
			if (found) begin
				for (int i = 0; i < chi_pkg::BUCKET_DEPTH - 1; i++) begin
					if (chi_pkg::IDX_W'(i) >= idx)
						new_row[i] = rd_row[i+1];
				end
				new_fill   = fill - chi_pkg::FILL_W'(1);
				new_status = chi_pkg::ST_DELETED;
				row_we     = exec;
			end else begin
				new_status = chi_pkg::ST_NO_MATCH;
			end
		end
	end

	// current request and result payload
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head_task;
		if (exec) begin
			status_q <= new_status;
			bucket_q <= cur_q.bucket;
		end
	end

	// control, fill counts and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			for (int b = 0; b < chi_pkg::MAX_BUCKETS; b++)
				fill_q[b] <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop)
						state_q <= B_EXEC;
				end
				B_EXEC: begin
					if (exec)
						state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (exec) begin
				fill_q[cur_q.bucket] <= new_fill;
				out_valid_q          <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign bucket    = bucket_q;

endmodule
`default_nettype wire

// ===== rtl/chained_hash_insert_delete.sv =====
// An accepted input beat passes the remainder steps, the queue push, the row
// read, the row update and the output beat; a full queue or a held result stalls it.
// The front's remainder unit, retiring 4 key bits per cycle, sets the pace; it
// takes a new request when idle or pushing; the back, only after a row update.
// Reset: bucket_count returns to 7, all bucket fill counts clear at once;
// the key rows are not cleared and no clearing pass runs.
`default_nettype none
// ---------------------------------------------------------------------------
// chained_hash_insert_delete
// Separate-chaining hash table with division hashing: the front computes the
// bucket, a short queue decouples it from the back that edits bucket rows.
// ---------------------------------------------------------------------------
module chained_hash_insert_delete (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         req_type,
	input  wire logic [chi_pkg::KEY_BITS-1:0] key,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic [chi_pkg::BKT_W-1:0]         bucket,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [chi_pkg::CFG_W-1:0]    cfg_data
);

	logic [chi_pkg::CFG_W-1:0] bucket_count_q;
	logic [chi_pkg::CNT_W-1:0] n;
	logic                      push;
	chi_pkg::task_t            push_task;
	logic                      fifo_full;
	logic                      pop;
	chi_pkg::task_t            head_task;
	logic                      fifo_empty;

	// configuration register, every write beat is taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bucket_count_q <= chi_pkg::CFG_W'(7);
		else if (cfg_valid)
			bucket_count_q <= cfg_data;
	end

	assign n = chi_pkg::eff_count(bucket_count_q);

	// front: accept and hash
	chi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.key       (key),
		.n         (n),
		.push      (push),
		.push_task (push_task),
		.fifo_full (fifo_full)
	);

	// queue between front and back
	chi_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_task (push_task),
		.full      (fifo_full),
		.pop       (pop),
		.pop_task  (head_task),
		.empty     (fifo_empty)
	);

	// back: bucket row update and result
	chi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.head_task  (head_task),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.bucket     (bucket)
	);

endmodule
`default_nettype wire
